FILE: src/wts_pkg.sv
`default_nettype none
// ----------------------------------------------------------------------------
// wts_pkg
// Shared types and constants of the word token splitter: payload structs,
// scanner modes, sequencer states and the character codes it looks for.
// ----------------------------------------------------------------------------
package wts_pkg;

	localparam int PENDING_DEPTH = 16;
	localparam int PEND_AW       = (PENDING_DEPTH > 1) ? $clog2(PENDING_DEPTH) : 1;
	localparam int CNT_W         = $clog2(PENDING_DEPTH + 1);

	localparam logic [7:0] HIGH_BIT   = 8'h80;
	localparam logic [7:0] CH_PERCENT = 8'h25;
	localparam logic [7:0] CH_DOT     = 8'h2e;
	localparam logic [7:0] CH_MINUS   = 8'h2d;
	localparam logic [7:0] CH_PLUS    = 8'h2b;
	localparam logic [7:0] CH_COMMA   = 8'h2c;
	localparam logic [7:0] CH_UNDER   = 8'h5f;
	localparam logic [7:0] CH_DOLLAR  = 8'h24;
	localparam logic [7:0] CH_0       = 8'h30;
	localparam logic [7:0] CH_9       = 8'h39;
	localparam logic [7:0] CH_UA      = 8'h41;
	localparam logic [7:0] CH_UZ      = 8'h5a;
	localparam logic [7:0] CH_LA      = 8'h61;
	localparam logic [7:0] CH_LZ      = 8'h7a;
	localparam logic [7:0] CASE_DIFF  = 8'h20;

	typedef struct packed {
		logic [7:0] data_byte;
		logic       end_of_message;
	} wts_in_t;

	typedef struct packed {
		logic [7:0] token_char;
		logic       has_char;
		logic       end_of_token;
		logic       last_of_run;
	} wts_out_t;

	typedef struct packed {
		logic [7:0] ch;
		logic       letter;
		logic       special;
		logic       starter;
	} wts_class_t;

	typedef enum logic [1:0] {
		MODE_WAITING = 2'd0,
		MODE_IN_WORD = 2'd1,
		MODE_PENDING = 2'd2
	} wts_mode_t;

	typedef enum logic [1:0] {
		ST_IDLE   = 2'd0,
		ST_FLUSH  = 2'd1,
		ST_LETTER = 2'd2
	} wts_state_t;

endpackage
`default_nettype wire

FILE: src/wts_ram.sv
`default_nettype none
// ----------------------------------------------------------------------------
// wts_ram
// Generic single-clock RAM, one write port and one read port with a
// registered read.
// ----------------------------------------------------------------------------
module wts_ram #(
	parameter int WIDTH  = 8,
	parameter int DEPTH  = 16,
	parameter int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
	input  wire logic              clk,
	input  wire logic              we,
	input  wire logic [ADDR_W-1:0] waddr,
	input  wire logic [WIDTH-1:0]  wdata,
	input  wire logic              re,
	input  wire logic [ADDR_W-1:0] raddr,
	output logic      [WIDTH-1:0]  rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		if (re) begin
			rdata <= mem_q[raddr];
		end
	end

endmodule
`default_nettype wire

FILE: src/wts_classify.sv
`default_nettype none
// ----------------------------------------------------------------------------
// wts_classify
// Byte classifier: applies the high byte substitute, sorts the byte into
// letter, special and word starter, and lowercases it.
// ----------------------------------------------------------------------------
module wts_classify (
	input  wire logic [7:0]          data_byte,
	input  wire logic [7:0]          substitute,
	output wts_pkg::wts_class_t      cls
);
	import wts_pkg::*;

	logic [7:0] c;
	logic       is_upper;
	logic       is_lower;
	logic       is_digit;

	assign c = ((substitute != 8'd0) && ((data_byte & HIGH_BIT) != 8'd0)) ? substitute
		: data_byte;

	assign is_upper = (c >= CH_UA) && (c <= CH_UZ);
	assign is_lower = (c >= CH_LA) && (c <= CH_LZ);
	assign is_digit = (c >= CH_0) && (c <= CH_9);

	assign cls.letter  = ((c & HIGH_BIT) != 8'd0) || is_upper || is_lower || is_digit
		|| (c == CH_PERCENT);
	assign cls.special = (c == CH_DOT) || (c == CH_MINUS) || (c == CH_PLUS)
		|| (c == CH_COMMA) || (c == CH_UNDER) || (c == CH_DOLLAR);
	assign cls.starter = cls.letter || (c == CH_DOLLAR);
	assign cls.ch      = is_upper ? (c + CASE_DIFF) : c;

endmodule
`default_nettype wire

FILE: src/word_token_splitter.sv
`default_nettype none
// Results are registered in out_q. Throughput: one input beat per cycle while
// no held characters are released and the output is not stalled.
// A letter after n held specials makes n reads of the pending RAM (registered
// read port), one per cycle unless the output stalls, then one letter beat.
// Reset (arst_n, async, active low) clears mode, count and handshake state;
// the pending RAM is not cleared and needs no clearing pass.
// ----------------------------------------------------------------------------
// word_token_splitter
// Splits a byte stream into lowercased words; held special characters live
// in a small RAM and are replayed when a letter follows them.
// ----------------------------------------------------------------------------
module word_token_splitter (
	input  wire logic              clk,
	input  wire logic              arst_n,
	input  wire logic              in_valid,
	output logic                   in_stall,
	input  wire wts_pkg::wts_in_t  in_data,
	output logic                   out_valid,
	input  wire logic              out_stall,
	output wts_pkg::wts_out_t      out_data,
	input  wire logic              cfg_valid,
	output logic                   cfg_ready,
	input  wire logic [7:0]        cfg_data
);
	import wts_pkg::*;

	logic [7:0]        sub_q;
	wts_mode_t         mode_q, mode_d;
	logic [CNT_W-1:0]  count_q, count_d;
	logic [CNT_W-1:0]  idx_q, idx_d, idx_inc;
	logic [7:0]        letter_q, letter_d;
	wts_state_t        st_q, st_d;
	logic              out_valid_q;
	wts_out_t          out_q, out_next;
	logic              out_load;
	logic              out_free;
	logic              in_acc;
	logic              flush_start;
	logic              more_held;
	wts_class_t        cls;

	logic               ram_we;
	logic [PEND_AW-1:0] ram_waddr;
	logic [7:0]         ram_wdata;
	logic               ram_re;
	logic [PEND_AW-1:0] ram_raddr;
	logic [7:0]         ram_rdata;

	wts_classify u_classify (
		.data_byte  (in_data.data_byte),
		.substitute (sub_q),
		.cls        (cls)
	);

	wts_ram #(
		.WIDTH (8),
		.DEPTH (PENDING_DEPTH)
	) u_pending (
		.clk   (clk),
		.we    (ram_we),
		.waddr (ram_waddr),
		.wdata (ram_wdata),
		.re    (ram_re),
		.raddr (ram_raddr),
		.rdata (ram_rdata)
	);

	assign cfg_ready   = 1'b1;
	assign out_valid   = out_valid_q;
	assign out_data    = out_q;
	assign out_free    = !out_valid_q || !out_stall;
	assign in_stall    = (st_q != ST_IDLE) || !out_free;
	assign in_acc      = in_valid && !in_stall;
	assign flush_start = !in_data.end_of_message && (mode_q == MODE_PENDING) && cls.letter;
	assign idx_inc     = idx_q + 1'b1;
	assign more_held   = idx_inc < count_q;

	always_comb begin
		st_d = st_q;
		case (st_q)
			ST_IDLE: begin
				if (in_acc && flush_start) st_d = ST_FLUSH;
			end
			ST_FLUSH: begin
				if (out_free && !more_held) st_d = ST_LETTER;
			end
			ST_LETTER: begin
				if (out_free) st_d = ST_IDLE;
			end
			default: st_d = ST_IDLE;
		endcase
	end

	always_comb begin
		out_load  = 1'b0;
		out_next  = '0;
		ram_we    = 1'b0;
		ram_waddr = count_q[PEND_AW-1:0];
		ram_wdata = cls.ch;
		ram_re    = 1'b0;
		ram_raddr = '0;
		mode_d    = mode_q;
		count_d   = count_q;
		idx_d     = idx_q;
		letter_d  = letter_q;
		case (st_q)
			ST_IDLE: begin
				if (in_acc) begin
					if (in_data.end_of_message) begin
						if (mode_q != MODE_WAITING) begin
							out_load = 1'b1;
							out_next = '{token_char: 8'd0, has_char: 1'b0,
								end_of_token: 1'b1, last_of_run: 1'b1};
						end
						mode_d  = MODE_WAITING;
						count_d = '0;
					end else begin
						case (mode_q)
							MODE_IN_WORD: begin
								if (cls.letter) begin
									out_load = 1'b1;
									out_next = '{token_char: cls.ch, has_char: 1'b1,
										end_of_token: 1'b0, last_of_run: 1'b1};
								end else if (cls.special) begin
									ram_we    = 1'b1;
									ram_waddr = '0;
									count_d   = CNT_W'(1);
									mode_d    = MODE_PENDING;
								end else begin
									out_load = 1'b1;
									out_next = '{token_char: 8'd0, has_char: 1'b0,
										end_of_token: 1'b1, last_of_run: 1'b1};
									mode_d   = MODE_WAITING;
								end
							end
							MODE_PENDING: begin
								if (cls.letter) begin
									letter_d = cls.ch;
									ram_re   = 1'b1;
									idx_d    = '0;
									mode_d   = MODE_IN_WORD;
								end else if (cls.special) begin
									if (count_q < CNT_W'(PENDING_DEPTH)) begin
										ram_we  = 1'b1;
										count_d = count_q + 1'b1;
									end
								end else begin
									out_load = 1'b1;
									out_next = '{token_char: 8'd0, has_char: 1'b0,
										end_of_token: 1'b1, last_of_run: 1'b1};
									count_d  = '0;
									mode_d   = MODE_WAITING;
								end
							end
							default: begin
								count_d = '0;
								mode_d  = MODE_WAITING;
								if (cls.starter) begin
									out_load = 1'b1;
									out_next = '{token_char: cls.ch, has_char: 1'b1,
										end_of_token: 1'b0, last_of_run: 1'b1};
									mode_d   = MODE_IN_WORD;
								end
							end
						endcase
					end
				end
			end
			ST_FLUSH: begin
				if (out_free) begin
					out_load = 1'b1;
					out_next = '{token_char: ram_rdata, has_char: 1'b1,
						end_of_token: 1'b0, last_of_run: 1'b0};
					idx_d    = idx_inc;
					if (more_held) begin
						ram_re    = 1'b1;
						ram_raddr = idx_inc[PEND_AW-1:0];
					end
				end
			end
			ST_LETTER: begin
				if (out_free) begin
					out_load = 1'b1;
					out_next = '{token_char: letter_q, has_char: 1'b1,
						end_of_token: 1'b0, last_of_run: 1'b1};
					count_d  = '0;
				end
			end
			default: ;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			sub_q       <= 8'd0;
			mode_q      <= MODE_WAITING;
			count_q     <= '0;
			idx_q       <= '0;
			st_q        <= ST_IDLE;
			out_valid_q <= 1'b0;
		end else begin
			if (cfg_valid && cfg_ready) sub_q <= cfg_data;
			mode_q  <= mode_d;
			count_q <= count_d;
			idx_q   <= idx_d;
			st_q    <= st_d;
			if (out_load) begin
				out_valid_q <= 1'b1;
			end else if (!out_stall) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		letter_q <= letter_d;
		if (out_load) out_q <= out_next;
	end

`ifndef NO_ASSERTIONS
	a_pending_nonempty: assert property (@(posedge clk) disable iff (!arst_n)
		(mode_q == MODE_PENDING) |-> (count_q != '0))
		else $error("pending mode with no held characters");

	a_count_bound: assert property (@(posedge clk) disable iff (!arst_n)
		count_q <= CNT_W'(PENDING_DEPTH))
		else $error("pending count past capacity");

	a_flush_index: assert property (@(posedge clk) disable iff (!arst_n)
		(st_q == ST_FLUSH) |-> (idx_q < count_q))
		else $error("flush index past held characters");

	a_flush_entry: assert property (@(posedge clk) disable iff (!arst_n)
		(in_acc && flush_start) |=> (st_q == ST_FLUSH && idx_q == '0))
		else $error("letter after held characters did not start a flush");
`endif

endmodule
`default_nettype wire
